[hw/rtl/cmm_pkg.sv]
// Shared types and constants for the cubic Mandelbrot membership block.
package cmm_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned IN_W   = 16;
  localparam int unsigned ITER_W = 10;
  localparam int unsigned RAD_W  = 15;
  localparam int unsigned IN_FRAC = 12;

  // Configuration register indexes.
  localparam logic REG_ITER = 1'b0;
  localparam logic REG_RAD  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [ITER_W-1:0] ITER_RST = 10'd200;
  localparam logic [RAD_W-1:0]  RAD_RST  = 15'd8192;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_MUL,
    ST_FIN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic square;
    logic step;
    logic finish;
    logic diverged;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic over_limit;
  } sts_t;

endpackage

[hw/rtl/cmm_ctrl.sv]
// Sequencer for the escape-time loop: iteration count, divergence exit, output slot.
module cmm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cmm_pkg::ITER_W-1:0]     iter_count,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output cmm_pkg::cmd_t                  cmd,
  input  cmm_pkg::sts_t                  sts
);

  cmm_pkg::ctrl_state_t state_r, state_nxt;
  logic [cmm_pkg::ITER_W-1:0] n_r, n_nxt;
  logic div_r, div_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmm_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = cmm_pkg::ST_SQ;
      end
      cmm_pkg::ST_SQ: begin
        state_nxt = cmm_pkg::ST_MUL;
      end
      cmm_pkg::ST_MUL: begin
        if ((n_r != '0 && sts.over_limit) || n_r == iter_count) begin
          state_nxt = cmm_pkg::ST_FIN;
        end else begin
          state_nxt = cmm_pkg::ST_SQ;
        end
      end
      cmm_pkg::ST_FIN: begin
        if (slot_free) state_nxt = cmm_pkg::ST_IDLE;
      end
      default: state_nxt = cmm_pkg::ST_IDLE;
    endcase
  end

  // Outputs, commands and counter updates.
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    n_nxt     = n_r;
    div_nxt   = div_r;
    case (state_r)
      cmm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          n_nxt    = '0;
          div_nxt  = 1'b0;
        end
      end
      cmm_pkg::ST_SQ: begin
        cmd.square = 1'b1;
      end
      cmm_pkg::ST_MUL: begin
        // The squares now belong to the z of the last completed iteration.
        if (n_r != '0 && sts.over_limit) begin
          div_nxt = 1'b1;
        end else if (n_r != iter_count) begin
          cmd.step = 1'b1;
          n_nxt    = n_r + 1'b1;
        end
      end
      cmm_pkg::ST_FIN: begin
        cmd.diverged = div_r;
        if (slot_free) cmd.finish = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // The result item stays valid until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmm_pkg::ST_IDLE;
      n_r         <= '0;
      div_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/cmm_datapath.sv]
// Fixed-point datapath: z registers, square and cube multipliers, magnitude checks.
module cmm_datapath #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cmm_pkg::cmd_t                     cmd,
  output cmm_pkg::sts_t                     sts,
  input  logic signed [cmm_pkg::IN_W-1:0]   point_re,
  input  logic signed [cmm_pkg::IN_W-1:0]   point_im,
  input  logic [cmm_pkg::RAD_W-1:0]         escape_radius,
  output logic                              inside_res
);

  localparam int unsigned ZW  = FRAC_BITS + 5;       // z component, signed
  localparam int unsigned SXW = 2 * FRAC_BITS + 7;   // exact square, unsigned
  localparam int unsigned DW  = FRAC_BITS + 10;      // x^2 - 3y^2 style terms
  localparam int unsigned PW  = ZW + DW;             // cube products
  localparam int unsigned MW  = 2 * FRAC_BITS + 8;   // magnitude
  localparam int unsigned RW  = FRAC_BITS + 3;       // converted radius
  localparam int unsigned WW  = FRAC_BITS + 21;      // conversion scratch
  localparam int unsigned SHL = (FRAC_BITS >= cmm_pkg::IN_FRAC) ?
                                FRAC_BITS - cmm_pkg::IN_FRAC : 0;
  localparam int unsigned SHR = (FRAC_BITS >= cmm_pkg::IN_FRAC) ?
                                0 : cmm_pkg::IN_FRAC - FRAC_BITS;
  localparam logic [MW-1:0] DIV_LIMIT = MW'(16) << (2 * FRAC_BITS);
  localparam logic signed [PW-1:0] ZMAX = PW'(8) <<< FRAC_BITS;

  logic signed [ZW-1:0] x_r, y_r, c_re_r, c_im_r;
  logic [SXW-1:0]       sx_r, sy_r;
  logic [2*RW-1:0]      r2_r;
  logic                 res_r;

  logic signed [WW-1:0]   cre_w, cim_w;
  logic [WW-1:0]          rad_w;
  logic [RW-1:0]          rad_c;
  logic signed [2*ZW-1:0] xx, yy;
  logic signed [DW-1:0]   xs, ys, d_re, d_im;
  logic signed [PW-1:0]   p_re, p_im, s_re, s_im;
  logic signed [ZW-1:0]   x_new, y_new;
  logic [MW-1:0]          mag;

  // Q3.12 to internal format; arithmetic right shift rounds toward minus infinity.
  assign cre_w = (WW'(point_re) <<< SHL) >>> SHR;
  assign cim_w = (WW'(point_im) <<< SHL) >>> SHR;
  assign rad_w = (WW'(escape_radius) << SHL) >> SHR;
  assign rad_c = rad_w[RW-1:0];

  // Exact squares of the current z.
  assign xx = x_r * x_r;
  assign yy = y_r * y_r;

  // Cube terms from the registered squares.
  assign xs   = $signed(DW'(sx_r[SXW-1:FRAC_BITS]));
  assign ys   = $signed(DW'(sy_r[SXW-1:FRAC_BITS]));
  assign d_re = xs - ((ys <<< 1) + ys);
  assign d_im = ((xs <<< 1) + xs) - ys;
  assign p_re = x_r * d_re;
  assign p_im = y_r * d_im;
  assign s_re = (p_re >>> FRAC_BITS) + PW'(c_re_r);
  assign s_im = (p_im >>> FRAC_BITS) + PW'(c_im_r);

  // Saturate the new z to plus or minus eight.
  always_comb begin
    if (s_re > ZMAX) begin
      x_new = ZMAX[ZW-1:0];
    end else if (s_re < -ZMAX) begin
      x_new = -ZMAX[ZW-1:0];
    end else begin
      x_new = s_re[ZW-1:0];
    end
    if (s_im > ZMAX) begin
      y_new = ZMAX[ZW-1:0];
    end else if (s_im < -ZMAX) begin
      y_new = -ZMAX[ZW-1:0];
    end else begin
      y_new = s_im[ZW-1:0];
    end
  end

  // Squared magnitude and divergence test.
  assign mag            = MW'(sx_r) + MW'(sy_r);
  assign sts.over_limit = mag > DIV_LIMIT;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= '0;
      y_r    <= '0;
      c_re_r <= cre_w[ZW-1:0];
      c_im_r <= cim_w[ZW-1:0];
      r2_r   <= rad_c * rad_c;
    end else if (cmd.step) begin
      x_r <= x_new;
      y_r <= y_new;
    end
    if (cmd.square) begin
      sx_r <= xx[SXW-1:0];
      sy_r <= yy[SXW-1:0];
    end
  end

  // Result bit, updated when the item is handed to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= 1'b0;
    end else if (cmd.finish) begin
      res_r <= !cmd.diverged && (mag < MW'(r2_r));
    end
  end

  assign inside_res = res_r;

endmodule

[hw/rtl/cubic_mandelbrot_membership.sv]
// Top level of the cubic Mandelbrot membership test: config registers and wiring.
// Each item is one point c; the block iterates z = z^3 + c from z = 0 and returns
// 1 when z never left the radius-4 disc and ends strictly inside escape_radius.
// One item is handled at a time. The number of iterations run is iteration_count,
// or fewer when the point diverges early. Each iteration passes through the
// squaring multipliers (ST_SQ) and then the cube multipliers that update z
// (ST_MUL). A new item is accepted the cycle after a result enters the output
// register, even if that result has not yet been taken.
module cubic_mandelbrot_membership #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] point_re, [31:16] point_im
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] inside_res, [7:1] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [cmm_pkg::ITER_W-1:0] iter_r;
  logic [cmm_pkg::RAD_W-1:0]  rad_r;
  logic                       cfg_wr;
  cmm_pkg::cmd_t              cmd;
  cmm_pkg::sts_t              sts;
  logic                       inside_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= cmm_pkg::ITER_RST;
      rad_r  <= cmm_pkg::RAD_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        cmm_pkg::REG_ITER: iter_r <= cfg_pwdata[cmm_pkg::ITER_W-1:0];
        cmm_pkg::REG_RAD:  rad_r  <= cfg_pwdata[cmm_pkg::RAD_W-1:0];
        default: iter_r <= iter_r;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_paddr[2])
      cmm_pkg::REG_ITER: cfg_prdata = 32'(iter_r);
      cmm_pkg::REG_RAD:  cfg_prdata = 32'(rad_r);
      default:           cfg_prdata = '0;
    endcase
  end

  cmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .iter_count (iter_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cmm_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .point_re      (in_tdata[15:0]),
    .point_im      (in_tdata[31:16]),
    .escape_radius (rad_r),
    .inside_res    (inside_res)
  );

  assign out_tdata = {7'b0, inside_res};

endmodule

[bench/cmm_verdict_check.sv]
// Checker for the cubic Mandelbrot membership block: predicts and compares every result.
`timescale 1ns / 100ps

module cmm_verdict_check #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] point_re, [31:16] point_im
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,   // [0] inside_res, [7:1] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          verdicts_pending,
  output int          verdicts_checked,
  output int          inside_seen
);

  localparam logic [2:0] ADDR_ITER = {cmm_pkg::REG_ITER, 2'b00};
  localparam logic [2:0] ADDR_RAD  = {cmm_pkg::REG_RAD, 2'b00};
  localparam int FRAC_SHIFT = int'(FRAC_BITS) - int'(cmm_pkg::IN_FRAC);
  localparam longint Z_LIMIT = longint'(8) <<< FRAC_BITS;
  localparam longint DIVERGE_LIMIT = longint'(16) <<< (2 * FRAC_BITS);
  localparam int REPORT_MAX = 40;

  // One accepted point together with the setting it was run under.
  typedef struct {
    logic signed [cmm_pkg::IN_W-1:0] re;
    logic signed [cmm_pkg::IN_W-1:0] im;
    logic [cmm_pkg::ITER_W-1:0]      iters;
    logic [cmm_pkg::RAD_W-1:0]       radius;
    logic                            in_set;
  } point_verdict_t;

  point_verdict_t             verdict_q[$];
  logic [cmm_pkg::ITER_W-1:0] iter_cfg;
  logic [cmm_pkg::RAD_W-1:0]  radius_cfg;
  int                         errors = 0;
  int                         checked = 0;
  int                         insides = 0;

  // Q3.12 to the block's internal fraction width, flooring dropped bits.
  function automatic longint to_frac(input longint v);
    if (FRAC_SHIFT >= 0) return v <<< FRAC_SHIFT;
    return v >>> (-FRAC_SHIFT);
  endfunction

  function automatic longint clamp_z(input longint v);
    if (v > Z_LIMIT) return Z_LIMIT;
    if (v < -Z_LIMIT) return -Z_LIMIT;
    return v;
  endfunction

  // Runs z = z^3 + c from zero and decides whether the point stays inside the radius.
  function automatic logic predict_inside(input logic signed [cmm_pkg::IN_W-1:0] re,
                                          input logic signed [cmm_pkg::IN_W-1:0] im,
                                          input logic [cmm_pkg::ITER_W-1:0] iters,
                                          input logic [cmm_pkg::RAD_W-1:0] radius);
    longint c_re, c_im, zx, zy, sq_x, sq_y, cube_re, cube_im, mag, r;
    bit escaped;
    c_re = to_frac(longint'(re));
    c_im = to_frac(longint'(im));
    zx = 0;
    zy = 0;
    mag = 0;
    escaped = 1'b0;
    for (int n = 0; n < int'(iters); n++) begin
      sq_x = (zx * zx) >>> FRAC_BITS;
      sq_y = (zy * zy) >>> FRAC_BITS;
      cube_re = (zx * (sq_x - 3 * sq_y)) >>> FRAC_BITS;
      cube_im = (zy * (3 * sq_x - sq_y)) >>> FRAC_BITS;
      zx = clamp_z(cube_re + c_re);
      zy = clamp_z(cube_im + c_im);
      mag = zx * zx + zy * zy;
      if (mag > DIVERGE_LIMIT) begin
        escaped = 1'b1;
        break;
      end
    end
    r = to_frac(longint'({1'b0, radius}));
    return !escaped && (mag < r * r);
  endfunction

  always @(posedge clk) begin : watch
    point_verdict_t v;
    logic [31:0]    rd_exp;
    bit             rd_known;
    if (!rst_n) begin
      iter_cfg = cmm_pkg::ITER_RST;
      radius_cfg = cmm_pkg::RAD_RST;
      verdict_q.delete();
    end else begin
      // Register traffic: shadow the writes, check the reads.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        rd_known = 1'b1;
        case (cfg_paddr)
          ADDR_ITER: rd_exp = 32'(iter_cfg);
          ADDR_RAD:  rd_exp = 32'(radius_cfg);
          default:   rd_known = 1'b0;
        endcase
        if (cfg_pwrite) begin
          case (cfg_paddr)
            ADDR_ITER: iter_cfg = cfg_pwdata[cmm_pkg::ITER_W-1:0];
            ADDR_RAD:  radius_cfg = cfg_pwdata[cmm_pkg::RAD_W-1:0];
            default: ;
          endcase
        end else if (rd_known && cfg_prdata !== rd_exp) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
                     $time, cfg_paddr, rd_exp, cfg_prdata);
        end
      end

      // Every accepted point gets its verdict worked out right away.
      if (in_tvalid && in_tready) begin
        v.re = in_tdata[15:0];
        v.im = in_tdata[31:16];
        v.iters = iter_cfg;
        v.radius = radius_cfg;
        v.in_set = predict_inside(v.re, v.im, iter_cfg, radius_cfg);
        verdict_q.push_back(v);
      end

      // Each result is matched against the oldest outstanding verdict.
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: result 0x%0h with no point outstanding: %s %0b",
                     $time, out_tdata, "expected none, got", out_tdata[0]);
        end else begin
          v = verdict_q.pop_front();
          checked++;
          if (out_tdata[0] === 1'b1) insides++;
          if (out_tdata[0] !== v.in_set) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: inside_res for c=(%0d,%0d) iters=%0d radius=%0d: %s %0b, %s %0b",
                       $time, v.re, v.im, v.iters, v.radius,
                       "expected", v.in_set, "got", out_tdata[0]);
          end
          if (out_tdata[7:1] !== 7'd0) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: out_tdata padding: expected 0x0, got 0x%0h",
                       $time, out_tdata[7:1]);
          end
        end
      end
    end
    fail_count <= errors;
    verdicts_pending <= verdict_q.size();
    verdicts_checked <= checked;
    inside_seen <= insides;
  end

endmodule

[bench/tb_cubic_mandelbrot_membership.sv]
// Testbench top for the cubic Mandelbrot membership block: clock, stimulus and verdict.
`timescale 1ns / 100ps

module tb_cubic_mandelbrot_membership;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned STALL_MAX = 19;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned ITER_MAX = (1 << cmm_pkg::ITER_W) - 1;
  localparam int unsigned RAD_MAX = (1 << cmm_pkg::RAD_W) - 1;
  localparam int unsigned RANDOM_SETTINGS = 20;
  localparam int unsigned POINTS_PER_SETTING = 25;
  localparam logic [2:0] ADDR_ITER = {cmm_pkg::REG_ITER, 2'b00};
  localparam logic [2:0] ADDR_RAD  = {cmm_pkg::REG_RAD, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [15:0] point_re, [31:16] point_im
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [0] inside_res, [7:1] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          verdicts_pending;
  int          verdicts_checked;
  int          inside_seen;
  bit          sender_quiet = 1'b0;
  int          points_sent = 0;
  int          settings_used = 1;
  int unsigned idle_cycles = 0;

  cubic_mandelbrot_membership #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  cmm_verdict_check #(.FRAC_BITS(FRAC_BITS)) verdict_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending),
    .verdicts_checked(verdicts_checked), .inside_seen(inside_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one point, after a random gap unless sender_quiet is set, and holds it until accepted.
  task automatic send_point(input logic [cmm_pkg::IN_W-1:0] re,
                            input logic [cmm_pkg::IN_W-1:0] im);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    do @(posedge clk); while (!in_tready);
    points_sent++;
  endtask

  // Stops offering points and waits until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_pending != 0);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Moves the block to a new setting once it has gone idle, reading each register back.
  task automatic apply_setting(input int unsigned iters, input int unsigned radius);
    drain_results();
    repeat (4) @(posedge clk);
    apb_transfer(1'b1, ADDR_ITER, 32'(iters));
    apb_transfer(1'b0, ADDR_ITER, 32'd0);
    apb_transfer(1'b1, ADDR_RAD, 32'(radius));
    apb_transfer(1'b0, ADDR_RAD, 32'd0);
    settings_used++;
  endtask

  // Coordinates cluster near the set, with some wider and some over the full range.
  function automatic logic [cmm_pkg::IN_W-1:0] rand_coord();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 6) v = int'($urandom_range(0, 10240)) - 5120;
    else if (pick < 8) v = int'($urandom_range(0, 20480)) - 10240;
    else v = int'($urandom());
    return v[cmm_pkg::IN_W-1:0];
  endfunction

  // Mostly short runs, now and then long ones or the extremes.
  function automatic int unsigned rand_iters();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return ITER_MAX;
    if (pick < 4) return $urandom_range(41, 255);
    return $urandom_range(1, 40);
  endfunction

  function automatic int unsigned rand_radius();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return RAD_MAX;
    if (pick == 2) return $urandom_range(8000, 8400);
    if (pick < 7) return $urandom_range(4096, 16384);
    return $urandom_range(0, RAD_MAX);
  endfunction

  // Result side: random stalls once a result shows up, with stretches of none.
  initial begin
    int stall;
    int mode_left;
    bit no_stall;
    mode_left = 0;
    no_stall = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (mode_left == 0) begin
        no_stall = ($urandom_range(0, 3) == 0);
        mode_left = 30;
      end
      stall = no_stall ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      mode_left--;
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** cubic_mandelbrot_membership: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned iters;
    int unsigned radius;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: origin, field extremes, single LSBs, real and imaginary
    // units, and points that push z into saturation.
    send_point(16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000);
    send_point(16'h8000, 16'h7fff);
    send_point(16'h0001, 16'h0000);
    send_point(16'hffff, 16'h0000);
    send_point(16'(4096), 16'h0000);
    send_point(16'(-4096), 16'h0000);
    send_point(16'h0000, 16'(4096));
    send_point(16'(14336), 16'h0000);
    send_point(16'h0000, 16'(-14336));
    send_point(16'(1024), 16'(-1024));

    // No iterations at all: z stays at zero.
    apply_setting(0, RAD_MAX);
    send_point(16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000);

    // Longest run against a zero radius: nothing can be inside.
    apply_setting(ITER_MAX, 0);
    send_point(16'h0000, 16'h0000);
    send_point(16'h0000, 16'(4096));
    send_point(16'(-2048), 16'h0000);

    // One iteration with the smallest nonzero radius: the strict compare.
    apply_setting(1, 1);
    send_point(16'h0000, 16'h0000);
    send_point(16'h0001, 16'h0000);
    send_point(16'h0000, 16'hffff);

    // Random settings, each with a batch of random points.
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      iters = (s == 2) ? ITER_MAX : rand_iters();
      radius = (s == 3) ? RAD_MAX : rand_radius();
      apply_setting(iters, radius);
      sender_quiet = ($urandom_range(0, 3) == 0);
      repeat (POINTS_PER_SETTING) send_point(rand_coord(), rand_coord());
    end

    drain_results();
    repeat (2 * ITER_MAX + 8) @(posedge clk);

    $display("Sent %0d points over %0d register settings; %0d results checked, %0d inside.",
             points_sent, settings_used, verdicts_checked, inside_seen);
    $display("Settings spanned iteration counts 0 to %0d and radii 0 to %0d.",
             ITER_MAX, RAD_MAX);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("** cubic_mandelbrot_membership: PASSED **");
    end else begin
      $display("** cubic_mandelbrot_membership: FAILED **");
    end
    $finish;
  end

endmodule
